FILE: hdl/lpfd_pkg.sv
// Shared types and constants for the length-prefixed frame deframer.
package lpfd_pkg;

    localparam int LPFD_BYTE_W      = 8;
    localparam int LPFD_WORD_W      = 16;
    localparam int LPFD_CLIENT_W    = 32;
    localparam int LPFD_QUEUE_DEPTH = 4;

    // Header byte positions; bytes beyond the client id are discarded.
    localparam logic [3:0] HDR_LEN_LO    = 4'd0;
    localparam logic [3:0] HDR_LEN_HI    = 4'd1;
    localparam logic [3:0] HDR_KIND_LO   = 4'd2;
    localparam logic [3:0] HDR_KIND_HI   = 4'd3;
    localparam logic [3:0] HDR_SEND_LO   = 4'd4;
    localparam logic [3:0] HDR_SEND_HI   = 4'd5;
    localparam logic [3:0] HDR_CLIENT_B0 = 4'd6;
    localparam logic [3:0] HDR_CLIENT_B1 = 4'd7;
    localparam logic [3:0] HDR_CLIENT_B2 = 4'd8;
    localparam logic [3:0] HDR_CLIENT_B3 = 4'd9;
    localparam logic [3:0] HDR_END       = 4'd10;

    typedef enum logic [1:0] {
        PH_LEN = 2'd0,
        PH_HDR = 2'd1,
        PH_PAY = 2'd2
    } phase_t;

    typedef struct packed {
        logic [LPFD_BYTE_W-1:0]          payload_byte;
        logic                            payload_valid;
        logic                            frame_end;
        logic [LPFD_WORD_W-1:0]          payload_length;
        logic [LPFD_WORD_W-1:0]          packet_kind;
        logic [LPFD_WORD_W-1:0]          sender_kind;
        logic signed [LPFD_CLIENT_W-1:0] client_id;
    } result_t;

endpackage

FILE: hdl/lpfd_byte_if.sv
// Input byte channel: valid/ready with one received byte.
interface lpfd_byte_if;
    logic                            valid;
    logic                            ready;
    logic [lpfd_pkg::LPFD_BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

FILE: hdl/lpfd_result_if.sv
// Output result channel: valid/ready with payload byte and header fields.
interface lpfd_result_if;
    logic                                   valid;
    logic                                   ready;
    logic [lpfd_pkg::LPFD_BYTE_W-1:0]        payload_byte;
    logic                                   payload_valid;
    logic                                   frame_end;
    logic [lpfd_pkg::LPFD_WORD_W-1:0]        payload_length;
    logic [lpfd_pkg::LPFD_WORD_W-1:0]        packet_kind;
    logic [lpfd_pkg::LPFD_WORD_W-1:0]        sender_kind;
    logic signed [lpfd_pkg::LPFD_CLIENT_W-1:0] client_id;

    modport source (output valid, output payload_byte, output payload_valid,
                    output frame_end, output payload_length, output packet_kind,
                    output sender_kind, output client_id, input ready);
    modport sink   (input valid, input payload_byte, input payload_valid,
                    input frame_end, input payload_length, input packet_kind,
                    input sender_kind, input client_id, output ready);
endinterface

FILE: hdl/length_prefixed_frame_deframer_top.sv
// A result is queued as its byte is accepted and then registered in the output stage.
// Throughput: one byte per cycle unless the queue is full (in_ch.ready is then low).
// A QUEUE_DEPTH-entry result queue lets input flow while the output stalls, until full.
// Reset (rst_n, asynchronous, active low) returns the parser to waiting for a
// header-length byte and empties the queue and output register.
module length_prefixed_frame_deframer_top #(
    parameter int QUEUE_DEPTH = lpfd_pkg::LPFD_QUEUE_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    lpfd_byte_if.sink     in_ch,
    lpfd_result_if.source out_ch
);
    import lpfd_pkg::*;

    logic    q_full;
    logic    q_push;
    logic    q_pop;
    logic    q_not_empty;
    result_t q_wr_data;
    result_t q_rd_data;

    lpfd_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .q_full (q_full),
        .q_push (q_push),
        .q_data (q_wr_data)
    );

    lpfd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .wr_data   (q_wr_data),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .rd_data   (q_rd_data)
    );

    lpfd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_data      (q_rd_data),
        .q_pop       (q_pop),
        .out_ch      (out_ch)
    );

endmodule

FILE: hdl/lpfd_front.sv
// Frame parser: takes bytes, tracks frame phase, pushes results into the queue.
module lpfd_front (
    input  logic                clk,
    input  logic                rst_n,
    lpfd_byte_if.sink           in_ch,
    input  logic                q_full,
    output logic                q_push,
    output lpfd_pkg::result_t   q_data
);
    import lpfd_pkg::*;

    phase_t                   phase_reg, phase_next;
    logic [LPFD_BYTE_W-1:0]   hdr_left_reg, hdr_left_next;
    logic [3:0]               hdr_idx_reg, hdr_idx_next;
    logic [LPFD_WORD_W-1:0]   pay_left_reg, pay_left_next;
    logic [LPFD_WORD_W-1:0]   cap_len_reg, cap_len_next;
    logic [LPFD_WORD_W-1:0]   cap_kind_reg, cap_kind_next;
    logic [LPFD_WORD_W-1:0]   cap_send_reg, cap_send_next;
    logic [LPFD_CLIENT_W-1:0] cap_client_reg, cap_client_next;

    logic                     accept;
    logic [LPFD_BYTE_W-1:0]   b;
    logic [LPFD_BYTE_W-1:0]   hdr_left_dec;
    logic                     hdr_done;
    logic                     pay_last;

    assign in_ch.ready = !q_full;
    assign accept      = in_ch.valid && !q_full;
    assign b           = in_ch.rx_byte;

    assign hdr_left_dec = (hdr_left_reg != '0) ? hdr_left_reg - 1'b1 : hdr_left_reg;
    assign hdr_done     = (hdr_left_dec == '0);
    assign pay_last     = (pay_left_reg <= LPFD_WORD_W'(1));

    // Datapath and result generation
    always_comb
    begin
        hdr_left_next   = hdr_left_reg;
        hdr_idx_next    = hdr_idx_reg;
        pay_left_next   = pay_left_reg;
        cap_len_next    = cap_len_reg;
        cap_kind_next   = cap_kind_reg;
        cap_send_next   = cap_send_reg;
        cap_client_next = cap_client_reg;
        q_push          = 1'b0;
        q_data          = '0;

        if (accept)
        begin
            unique case (phase_reg)
                PH_HDR:
                begin
                    case (hdr_idx_reg)
                        HDR_LEN_LO:    cap_len_next[7:0]       = b;
                        HDR_LEN_HI:    cap_len_next[15:8]      = b;
                        HDR_KIND_LO:   cap_kind_next[7:0]      = b;
                        HDR_KIND_HI:   cap_kind_next[15:8]     = b;
                        HDR_SEND_LO:   cap_send_next[7:0]      = b;
                        HDR_SEND_HI:   cap_send_next[15:8]     = b;
                        HDR_CLIENT_B0: cap_client_next[7:0]    = b;
                        HDR_CLIENT_B1: cap_client_next[15:8]   = b;
                        HDR_CLIENT_B2: cap_client_next[23:16]  = b;
                        HDR_CLIENT_B3: cap_client_next[31:24]  = b;
                        default: ;
                    endcase
                    if (hdr_idx_reg != HDR_END)
                        hdr_idx_next = hdr_idx_reg + 1'b1;
                    hdr_left_next = hdr_left_dec;
                    if (hdr_done)
                    begin
                        if (cap_len_next == '0)
                            q_push = 1'b1;
                        else
                            pay_left_next = cap_len_next;
                    end
                    q_data.frame_end = 1'b1;
                end
                PH_PAY:
                begin
                    q_push               = 1'b1;
                    q_data.payload_byte  = b;
                    q_data.payload_valid = 1'b1;
                    q_data.frame_end     = pay_last;
                    if (pay_last)
                        pay_left_next = '0;
                    else
                        pay_left_next = pay_left_reg - 1'b1;
                end
                default:
                begin
                    // header-length byte: a zero length closes the frame at once
                    cap_len_next    = '0;
                    cap_kind_next   = '0;
                    cap_send_next   = '0;
                    cap_client_next = '0;
                    hdr_idx_next    = '0;
                    hdr_left_next   = b;
                    q_data.frame_end = 1'b1;
                    if (b == '0)
                        q_push = 1'b1;
                end
            endcase
        end

        q_data.payload_length = cap_len_next;
        q_data.packet_kind    = cap_kind_next;
        q_data.sender_kind    = cap_send_next;
        q_data.client_id      = $signed(cap_client_next);
    end

    // Next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (accept)
        begin
            unique case (phase_reg)
                PH_HDR:
                begin
                    if (hdr_done)
                        phase_next = (cap_len_next == '0) ? PH_LEN : PH_PAY;
                end
                PH_PAY:
                begin
                    if (pay_last)
                        phase_next = PH_LEN;
                end
                default:
                begin
                    phase_next = (b == '0) ? PH_LEN : PH_HDR;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_LEN;
            hdr_left_reg   <= '0;
            hdr_idx_reg    <= '0;
            pay_left_reg   <= '0;
            cap_len_reg    <= '0;
            cap_kind_reg   <= '0;
            cap_send_reg   <= '0;
            cap_client_reg <= '0;
        end
        else
        begin
            phase_reg      <= phase_next;
            hdr_left_reg   <= hdr_left_next;
            hdr_idx_reg    <= hdr_idx_next;
            pay_left_reg   <= pay_left_next;
            cap_len_reg    <= cap_len_next;
            cap_kind_reg   <= cap_kind_next;
            cap_send_reg   <= cap_send_next;
            cap_client_reg <= cap_client_next;
        end
    end

endmodule

FILE: hdl/lpfd_queue.sv
// Short result queue between the parser and the output stage.
module lpfd_queue #(
    parameter int DEPTH = lpfd_pkg::LPFD_QUEUE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  lpfd_pkg::result_t wr_data,
    output logic              full,
    input  logic              pop,
    output logic              not_empty,
    output lpfd_pkg::result_t rd_data
);
    import lpfd_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    result_t         mem [DEPTH];
    result_t         rd_data_reg;
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            do_push, do_pop;

    assign full      = (count_reg == FULL_CNT);
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign rd_data   = rd_data_reg;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= wr_data;
    end

    // head entry is read ahead; a write landing on the next head is forwarded
    always_ff @(posedge clk)
    begin
        if (do_push && (wr_ptr_reg == rd_ptr_next))
            rd_data_reg <= wr_data;
        else
            rd_data_reg <= mem[rd_ptr_next];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: hdl/lpfd_back.sv
// Output stage: registers queued results onto the result channel.
module lpfd_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_not_empty,
    input  lpfd_pkg::result_t q_data,
    output logic              q_pop,
    lpfd_result_if.source     out_ch
);
    import lpfd_pkg::*;

    logic    out_valid_reg, out_valid_next;
    result_t out_data_reg;
    logic    load;

    // refill whenever the register is empty or its transfer completes
    assign load  = q_not_empty && (!out_valid_reg || out_ch.ready);
    assign q_pop = load;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
            out_valid_next = 1'b1;
        else if (out_ch.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            out_data_reg <= q_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.payload_byte   = out_data_reg.payload_byte;
    assign out_ch.payload_valid  = out_data_reg.payload_valid;
    assign out_ch.frame_end      = out_data_reg.frame_end;
    assign out_ch.payload_length = out_data_reg.payload_length;
    assign out_ch.packet_kind    = out_data_reg.packet_kind;
    assign out_ch.sender_kind    = out_data_reg.sender_kind;
    assign out_ch.client_id      = out_data_reg.client_id;

endmodule

FILE: sim/tb_length_prefixed_frame_deframer_top.sv
// Testbench for the frame deframer: directed table, then random frames against a predictor.
`timescale 1ns / 1ps

module tb_length_prefixed_frame_deframer_top;
    import lpfd_pkg::*;

    localparam int CLK_HALF     = 10;
    localparam int RESET_CYCLES = 12;
    localparam int BYTE_TARGET  = 1350;
    localparam int DRAIN_CYCLES = 12;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int REPORT_MAX   = 10;
    localparam int DIR_ROWS     = 25;

    typedef struct {
        logic [LPFD_BYTE_W-1:0] rx;
        bit                     fixed;
        result_t                want;
    } stim_row_t;

    logic clk;
    logic rst_n;

    lpfd_byte_if   in_ch ();
    lpfd_result_if out_ch ();

    length_prefixed_frame_deframer_top u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // Predictor state
    phase_t                   fr_phase;
    logic [7:0]               fr_hdr_left;
    logic [7:0]               fr_hdr_idx;
    logic [LPFD_WORD_W-1:0]   fr_pay_left;
    logic [LPFD_WORD_W-1:0]   fr_len;
    logic [LPFD_WORD_W-1:0]   fr_kind;
    logic [LPFD_WORD_W-1:0]   fr_send;
    logic [LPFD_CLIENT_W-1:0] fr_client;

    result_t pending_results[$];
    int      fault_count;
    int      bytes_sent;
    int      cycle_count;
    bit      send_calm;

    // Extremes, short/long/empty header and empty payload, with the obvious results typed in
    stim_row_t directed_rows [DIR_ROWS] = '{
        '{8'h00, 1'b1, result_t'{8'h00, 1'b0, 1'b1, 16'h0000, 16'h0000, 16'h0000, 32'sh0}},
        '{8'h02, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'h00, 1'b1, result_t'{8'h00, 1'b0, 1'b1, 16'h0000, 16'h0000, 16'h0000, 32'sh0}},
        '{8'h04, 1'b0, '0},
        '{8'h01, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'hAB, 1'b0, '0},
        '{8'hCD, 1'b0, '0},
        '{8'hFF, 1'b1, result_t'{8'hFF, 1'b1, 1'b1, 16'h0001, 16'hCDAB, 16'h0000, 32'sh0}},
        '{8'h0C, 1'b0, '0},
        '{8'h02, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'hFF, 1'b0, '0},
        '{8'hFF, 1'b0, '0},
        '{8'hFF, 1'b0, '0},
        '{8'hFF, 1'b0, '0},
        '{8'hFF, 1'b0, '0},
        '{8'hFF, 1'b0, '0},
        '{8'hFF, 1'b0, '0},
        '{8'hFF, 1'b0, '0},
        '{8'h55, 1'b0, '0},
        '{8'hAA, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'hFF, 1'b1, result_t'{8'hFF, 1'b1, 1'b1, 16'h0002, 16'hFFFF, 16'hFFFF, -32'sd1}}
    };

    function automatic result_t frame_result(input logic [7:0] b, input bit valid,
                                             input bit last);
        result_t r;
        r.payload_byte   = b;
        r.payload_valid  = valid;
        r.frame_end      = last;
        r.payload_length = fr_len;
        r.packet_kind    = fr_kind;
        r.sender_kind    = fr_send;
        r.client_id      = fr_client;
        return r;
    endfunction

    function automatic bit close_header(output result_t r);
        r = '0;
        if (fr_len == '0) begin
            r = frame_result(8'h00, 1'b0, 1'b1);
            fr_phase = PH_LEN;
            return 1'b1;
        end
        fr_pay_left = fr_len;
        fr_phase = PH_PAY;
        return 1'b0;
    endfunction

    // Advances the deframer state by one byte; returns 1 when a result is due
    function automatic bit deframe_byte(input logic [7:0] b, output result_t r);
        bit emitted;
        bit last_byte;
        emitted = 1'b0;
        r = '0;
        case (fr_phase)
            PH_HDR: begin
                if (fr_hdr_idx < HDR_KIND_LO)
                    fr_len = fr_len | (16'(b) << (8 * fr_hdr_idx));
                else if (fr_hdr_idx < HDR_SEND_LO)
                    fr_kind = fr_kind | (16'(b) << (8 * (fr_hdr_idx - HDR_KIND_LO)));
                else if (fr_hdr_idx < HDR_CLIENT_B0)
                    fr_send = fr_send | (16'(b) << (8 * (fr_hdr_idx - HDR_SEND_LO)));
                else if (fr_hdr_idx < HDR_END)
                    fr_client = fr_client | (32'(b) << (8 * (fr_hdr_idx - HDR_CLIENT_B0)));
                if (fr_hdr_idx != 8'hFF)
                    fr_hdr_idx = fr_hdr_idx + 8'd1;
                if (fr_hdr_left != 8'd0)
                    fr_hdr_left = fr_hdr_left - 8'd1;
                if (fr_hdr_left == 8'd0)
                    emitted = close_header(r);
            end
            PH_PAY: begin
                last_byte = (fr_pay_left <= 16'd1);
                r = frame_result(b, 1'b1, last_byte);
                emitted = 1'b1;
                if (fr_pay_left != '0)
                    fr_pay_left = fr_pay_left - 16'd1;
                if (last_byte) begin
                    fr_pay_left = '0;
                    fr_phase = PH_LEN;
                end
            end
            default: begin
                // header-length byte; also covers the unused phase code
                fr_len      = '0;
                fr_kind     = '0;
                fr_send     = '0;
                fr_client   = '0;
                fr_hdr_idx  = 8'd0;
                fr_hdr_left = b;
                if (b == 8'd0)
                    emitted = close_header(r);
                else
                    fr_phase = PH_HDR;
            end
        endcase
        return emitted;
    endfunction

    function automatic int pick_gap(input bit calm);
        int roll;
        if (calm)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 65)
            return 0;
        if (roll < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_byte(input logic [7:0] b, output bit has_res, output result_t r);
        int gap;
        gap = pick_gap(send_calm);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.rx_byte <= b;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        has_res = deframe_byte(b, r);
        bytes_sent++;
    endtask

    task automatic hold_until_drained();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // One frame, mostly well formed, sometimes with a short, long or random header length
    task automatic build_frame(ref logic [7:0] frame_q[$]);
        int roll;
        int hdr_len;
        int pay_len;
        int pay_count;
        roll = $urandom_range(0, 99);
        pay_len = $urandom_range(0, 16);
        if (roll < 62)
            hdr_len = 10;
        else if (roll < 72)
            hdr_len = $urandom_range(0, 9);
        else if (roll < 82)
            hdr_len = $urandom_range(11, 40);
        else if (roll < 84) begin
            hdr_len = 255;
            pay_len = $urandom_range(0, 8);
        end else if (roll < 87) begin
            hdr_len = 10;
            pay_len = $urandom_range(200, 320);
        end else if (roll < 92) begin
            hdr_len = 10;
            pay_len = 0;
        end else begin
            hdr_len = $urandom_range(0, 255);
            pay_len = $urandom_range(0, 511);
        end
        frame_q.push_back(8'(hdr_len));
        for (int i = 0; i < hdr_len; i++) begin
            if (i == 0)
                frame_q.push_back(pay_len[7:0]);
            else if (i == 1)
                frame_q.push_back(pay_len[15:8]);
            else
                frame_q.push_back(8'($urandom));
        end
        // a truncated header leaves the missing length bytes at zero
        if (hdr_len == 0)
            pay_count = 0;
        else if (hdr_len == 1)
            pay_count = pay_len & 8'hFF;
        else
            pay_count = pay_len;
        for (int i = 0; i < pay_count; i++)
            frame_q.push_back(8'($urandom));
    endtask

    initial begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[length_prefixed_frame_deframer_top] ERROR");
        $finish;
    end

    // Sink side: random stalls with calm stretches
    initial begin
        int  stall;
        int  calm_left;
        bit  calm;
        stall = 0;
        calm_left = 0;
        calm = 1'b0;
        out_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            @(posedge clk);
            if (calm_left == 0) begin
                calm = ($urandom_range(0, 3) == 0);
                calm_left = $urandom_range(64, 512);
            end else
                calm_left--;
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                stall--;
            end else begin
                out_ch.ready <= 1'b1;
                if (!calm)
                    stall = pick_gap(1'b0);
            end
        end
    end

    // Result checker
    always @(posedge clk) begin
        result_t got;
        result_t want;
        if (rst_n && out_ch.valid && out_ch.ready) begin
            got.payload_byte   = out_ch.payload_byte;
            got.payload_valid  = out_ch.payload_valid;
            got.frame_end      = out_ch.frame_end;
            got.payload_length = out_ch.payload_length;
            got.packet_kind    = out_ch.packet_kind;
            got.sender_kind    = out_ch.sender_kind;
            got.client_id      = out_ch.client_id;
            if (pending_results.size() == 0) begin
                fault_count++;
                if (fault_count <= REPORT_MAX)
                    $display("unexpected result: byte=%02h v=%0b end=%0b len=%04h",
                             got.payload_byte, got.payload_valid, got.frame_end,
                             got.payload_length);
            end else begin
                want = pending_results.pop_front();
                if (got.payload_byte !== want.payload_byte ||
                    got.payload_valid !== want.payload_valid ||
                    got.frame_end !== want.frame_end ||
                    got.payload_length !== want.payload_length ||
                    got.packet_kind !== want.packet_kind ||
                    got.sender_kind !== want.sender_kind ||
                    got.client_id !== want.client_id) begin
                    fault_count++;
                    if (fault_count <= REPORT_MAX) begin
                        $display("mismatch exp: byte=%02h v=%0b end=%0b len=%04h kind=%04h snd=%04h cid=%08h",
                                 want.payload_byte, want.payload_valid, want.frame_end,
                                 want.payload_length, want.packet_kind, want.sender_kind,
                                 want.client_id);
                        $display("         got: byte=%02h v=%0b end=%0b len=%04h kind=%04h snd=%04h cid=%08h",
                                 got.payload_byte, got.payload_valid, got.frame_end,
                                 got.payload_length, got.packet_kind, got.sender_kind,
                                 got.client_id);
                    end
                end
            end
        end
    end

    // Stimulus
    initial begin
        logic [7:0] frame_q[$];
        bit         has_res;
        result_t    res;
        fault_count   = 0;
        bytes_sent    = 0;
        send_calm     = 1'b0;
        fr_phase      = PH_LEN;
        fr_hdr_left   = '0;
        fr_hdr_idx    = '0;
        fr_pay_left   = '0;
        fr_len        = '0;
        fr_kind       = '0;
        fr_send       = '0;
        fr_client     = '0;
        in_ch.valid   = 1'b0;
        in_ch.rx_byte = '0;
        rst_n         = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i]) begin
            send_byte(directed_rows[i].rx, has_res, res);
            if (directed_rows[i].fixed)
                pending_results.push_back(directed_rows[i].want);
            else if (has_res)
                pending_results.push_back(res);
        end
        hold_until_drained();

        while (bytes_sent < BYTE_TARGET) begin
            // now and then hold the sender until the output has caught up
            if ($urandom_range(0, 99) < 3)
                hold_until_drained();
            send_calm = ($urandom_range(0, 3) == 0);
            frame_q.delete();
            build_frame(frame_q);
            foreach (frame_q[i]) begin
                send_byte(frame_q[i], has_res, res);
                if (has_res)
                    pending_results.push_back(res);
            end
        end

        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fault_count == 0)
            $display("[length_prefixed_frame_deframer_top] OK");
        else
            $display("[length_prefixed_frame_deframer_top] ERROR");
        $finish;
    end

endmodule

FILE: filelist.f
hdl/lpfd_pkg.sv
hdl/lpfd_byte_if.sv
hdl/lpfd_result_if.sv
hdl/lpfd_front.sv
hdl/lpfd_queue.sv
hdl/lpfd_back.sv
hdl/length_prefixed_frame_deframer_top.sv
sim/tb_length_prefixed_frame_deframer_top.sv
